// File: rtl/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants of the byte ring buffer: payload structs,
// operation and status codes, controller state and controller/datapath links.
// ----------------------------------------------------------------------------
package brb_pkg;

   // ring geometry
   localparam int CAPACITY   = 1024;
   localparam int INDEX_BITS = 32;
   localparam int ADDR_BITS  = $clog2(CAPACITY);

   // fixed field widths of the ports
   localparam int PORT_INDEX_BITS = 32;
   localparam int FILL_COUNT_BITS = 11;
   localparam int BYTE_BITS       = 8;

   // both indices start at minus 500, wrapped
   localparam logic [INDEX_BITS-1:0] RESET_INDEX = ~INDEX_BITS'(499);
   localparam logic [INDEX_BITS-1:0] CAPACITY_INDEX = INDEX_BITS'(CAPACITY);

   // operation codes
   typedef enum logic [1:0] {
      KIND_PUSH  = 2'd0,
      KIND_POP   = 2'd1,
      KIND_WRITE = 2'd2,
      KIND_READ  = 2'd3
   } kind_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_BLOCK = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   // ram address source
   typedef enum logic [1:0] {
      ADDR_END,
      ADDR_START,
      ADDR_INDEX
   } addr_sel_type;

   // input item
   typedef struct packed {
      kind_type                   kind;
      logic [BYTE_BITS-1:0]       write_data;
      logic [PORT_INDEX_BITS-1:0] index;
      logic                       last;
   } req_type;

   // result item
   typedef struct packed {
      status_type                 status;
      logic [BYTE_BITS-1:0]       read_data;
      logic [FILL_COUNT_BITS-1:0] fill_count;
      logic [PORT_INDEX_BITS-1:0] first_index;
      logic [PORT_INDEX_BITS-1:0] next_index;
      logic                       run_end;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic         load;
      logic         exec;
      logic         mem_we;
      logic         mem_re;
      addr_sel_type addr_sel;
      logic         adv_start;
      logic         adv_end;
      status_type   code;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      kind_type kind;
      logic     full;
      logic     empty;
      logic     in_range;
      logic     at_end;
   } dp_status_type;

endpackage

// File: rtl/brb_ram.sv
// ----------------------------------------------------------------------------
// brb_ram
// Generic single-port RAM with one write and one read per cycle at a shared
// address and registered read data.
// ----------------------------------------------------------------------------
module brb_ram #(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH      = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [DATA_WIDTH-1:0]    wdata,
   output logic [DATA_WIDTH-1:0]    rdata
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rdata_ff;

   // storage write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/brb_ctrl.sv
// ----------------------------------------------------------------------------
// brb_ctrl
// Controller of the byte ring buffer: capture, execute and respond sequence,
// operation decode into datapath commands, overwrite mode register.
// ----------------------------------------------------------------------------
module brb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_data,
   input  brb_pkg::dp_status_type status,
   output brb_pkg::dp_cmd_type    cmd,
   output logic                   rsp_valid
);
   import brb_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      overwrite_ff;

   // configuration register, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         overwrite_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         overwrite_ff <= csr_data;
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      busy          = 1'b1;
      rsp_valid     = 1'b0;
      cmd           = '0;
      cmd.addr_sel  = ADDR_END;
      cmd.code      = STATUS_OK;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_RESP;
            unique case (status.kind)
               KIND_PUSH: begin
                  if (status.full && !overwrite_ff) begin
                     cmd.code = STATUS_BLOCK;
                  end else begin
                     cmd.mem_we    = 1'b1;
                     cmd.addr_sel  = ADDR_END;
                     cmd.adv_end   = 1'b1;
                     cmd.adv_start = status.full;
                  end
               end
               KIND_POP: begin
                  if (status.empty) begin
                     cmd.code = STATUS_BLOCK;
                  end else begin
                     cmd.mem_re    = 1'b1;
                     cmd.addr_sel  = ADDR_START;
                     cmd.adv_start = 1'b1;
                  end
               end
               KIND_WRITE: begin
                  if (!status.in_range) begin
                     cmd.code = STATUS_RANGE;
                  end else begin
                     // writing at the end extends the ring
                     cmd.mem_we    = 1'b1;
                     cmd.addr_sel  = ADDR_INDEX;
                     cmd.adv_end   = status.at_end;
                     cmd.adv_start = status.at_end && status.full;
                  end
               end
               KIND_READ: begin
                  if (!status.in_range || status.at_end) begin
                     cmd.code = STATUS_RANGE;
                  end else begin
                     cmd.mem_re   = 1'b1;
                     cmd.addr_sel = ADDR_INDEX;
                  end
               end
               default: begin
                  cmd.code = STATUS_OK;
               end
            endcase
         end
         ST_RESP: begin
            rsp_valid   = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // checks
   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("result strobe not two cycles after accepted transfer");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_mem_one_access: assert property (@(posedge clock) disable iff (reset)
      !(cmd.mem_we && cmd.mem_re))
      else $error("ram read and write in the same cycle");

   a_no_accept_in_flight: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !cmd.load ##1 !cmd.load)
      else $error("transfer accepted while an item is in flight");

endmodule

// File: rtl/brb_datapath.sv
// ----------------------------------------------------------------------------
// brb_datapath
// Datapath of the byte ring buffer: request capture, start and end indices,
// range compares, byte store and result formatting.
// ----------------------------------------------------------------------------
module brb_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  brb_pkg::req_type       req,
   input  brb_pkg::dp_cmd_type    cmd,
   output brb_pkg::dp_status_type status,
   output brb_pkg::rsp_type       rsp
);
   import brb_pkg::*;

   req_type                 req_ff;
   logic [INDEX_BITS-1:0]   start_ff;
   logic [INDEX_BITS-1:0]   end_ff;
   status_type              code_ff;
   logic                    rd_flag_ff;

   logic [INDEX_BITS-1:0]   idx;
   logic [INDEX_BITS-1:0]   fill;
   logic [INDEX_BITS-1:0]   offset;
   logic [ADDR_BITS-1:0]    mem_addr;
   logic [BYTE_BITS-1:0]    mem_rdata;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req;
      end
   end

   // fill and position of the index relative to start
   assign idx    = INDEX_BITS'(req_ff.index);
   assign fill   = end_ff - start_ff;
   assign offset = idx - start_ff;

   assign status.kind     = req_ff.kind;
   assign status.full     = (fill >= CAPACITY_INDEX);
   assign status.empty    = (fill == '0);
   assign status.in_range = (offset <= fill);
   assign status.at_end   = (offset == fill);

   // index registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= RESET_INDEX;
         end_ff   <= RESET_INDEX;
      end else if (cmd.exec) begin
         if (cmd.adv_start) begin
            start_ff <= start_ff + INDEX_BITS'(1);
         end
         if (cmd.adv_end) begin
            end_ff <= end_ff + INDEX_BITS'(1);
         end
      end
   end

   // outcome of the executed item
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         code_ff    <= cmd.code;
         rd_flag_ff <= cmd.mem_re;
      end
   end

   // ram slot select
   always_comb begin
      case (cmd.addr_sel)
         ADDR_START: mem_addr = start_ff[ADDR_BITS-1:0];
         ADDR_INDEX: mem_addr = idx[ADDR_BITS-1:0];
         default:    mem_addr = end_ff[ADDR_BITS-1:0];
      endcase
   end

   brb_ram #(
      .DATA_WIDTH (BYTE_BITS),
      .DEPTH      (CAPACITY)
   ) u_store (
      .clock (clock),
      .we    (cmd.mem_we),
      .re    (cmd.mem_re),
      .addr  (mem_addr),
      .wdata (req_ff.write_data),
      .rdata (mem_rdata)
   );

   // result formatting
   assign rsp.status      = code_ff;
   assign rsp.read_data   = rd_flag_ff ? mem_rdata : '0;
   assign rsp.fill_count  = FILL_COUNT_BITS'(fill);
   assign rsp.first_index = PORT_INDEX_BITS'(start_ff);
   assign rsp.next_index  = PORT_INDEX_BITS'(end_ff);
   assign rsp.run_end     = req_ff.last;

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill <= CAPACITY_INDEX)
      else $error("ring holds more than its capacity");

   a_start_step: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && cmd.adv_start) |=> start_ff == $past(start_ff) + INDEX_BITS'(1))
      else $error("start index did not advance by one");

endmodule

// File: rtl/byte_ring_buffer_abs_index.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_abs_index
// Byte ring buffer addressed by wrapping absolute indices: push, pop, write
// and read at an index, with optional overwrite of the oldest byte.
// ----------------------------------------------------------------------------
// result: an accepted transfer goes through the execute state to the respond
//   state, in which the result strobe is high
// items: a new item is taken only after the last one has gone through the
//   controller's capture, execute and respond steps around the single-port store's registered read
// reset: both indices go to minus 500, overwrite mode off; the byte store is
//   not cleared, so no clearing pass and no wait after reset
// results are shown for one cycle; the receiver cannot stall
module byte_ring_buffer_abs_index (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  brb_pkg::req_type req_data,
   output logic             rsp_valid,
   output brb_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data
);
   import brb_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencing and decode
   brb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .status    (status),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   // indices, store and result
   brb_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req    (req_data),
      .cmd    (cmd),
      .status (status),
      .rsp    (rsp_data)
   );

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the byte ring buffer. A command-level predictor
// tracks the ring indices, the byte store and the overwrite mode and
// computes the result of every accepted command. A directed pass covers the
// empty ring and the range checks. Random passes then fill the ring, hover at
// full with overwrite off and on, and drain it. Sender gaps vary by pass.
// ----------------------------------------------------------------------------
module testbench;
   import brb_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;

   // clock, reset and block inputs, all known from time zero
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    start     = 1'b0;
   req_type req_data  = '0;
   logic    csr_valid = 1'b0;
   logic    csr_data  = 1'b0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_ready;

   // predictor state: byte store, oldest index, next push index, mode
   logic [BYTE_BITS-1:0]  ring_mem [CAPACITY];
   logic [INDEX_BITS-1:0] ring_head;
   logic [INDEX_BITS-1:0] ring_tail;
   bit                    wrap_mode;

   // results still to come, oldest first
   rsp_type ring_results_q [$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int idle_pct       = 0;

   byte_ring_buffer_abs_index i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   function automatic logic [INDEX_BITS-1:0] held_bytes();
      return ring_tail - ring_head;
   endfunction

   // a span [a,b] lies inside the held bytes
   function automatic bit span_ok(logic [INDEX_BITS-1:0] a, logic [INDEX_BITS-1:0] b);
      logic [INDEX_BITS-1:0] n;
      n = held_bytes();
      return ((b - a) <= n) && ((a - ring_head) <= n) && ((ring_tail - b) <= n);
   endfunction

   // drop the oldest bytes beyond the capacity
   function automatic void trim_head();
      if (held_bytes() > CAPACITY_INDEX) begin
         ring_head = ring_tail - CAPACITY_INDEX;
      end
   endfunction

   function automatic rsp_type ring_apply(req_type item);
      rsp_type               res;
      logic [INDEX_BITS-1:0] grown_tail;
      res         = '0;
      res.status  = STATUS_OK;
      res.run_end = item.last;
      case (item.kind)
         KIND_PUSH: begin
            if (!wrap_mode && held_bytes() >= CAPACITY_INDEX) begin
               res.status = STATUS_BLOCK;
            end else begin
               ring_mem[ring_tail[ADDR_BITS-1:0]] = item.write_data;
               ring_tail = ring_tail + INDEX_BITS'(1);
               trim_head();
            end
         end
         KIND_POP: begin
            if (held_bytes() == 0) begin
               res.status = STATUS_BLOCK;
            end else begin
               res.read_data = ring_mem[ring_head[ADDR_BITS-1:0]];
               ring_head = ring_head + INDEX_BITS'(1);
            end
         end
         KIND_WRITE: begin
            if (!span_ok(item.index, ring_tail)) begin
               res.status = STATUS_RANGE;
            end else begin
               // writing at the end extends the ring by one byte
               grown_tail = item.index + INDEX_BITS'(1);
               if (!span_ok(ring_head, grown_tail)) begin
                  ring_tail = grown_tail;
               end
               ring_mem[item.index[ADDR_BITS-1:0]] = item.write_data;
               trim_head();
            end
         end
         default: begin
            if (!span_ok(item.index, item.index + INDEX_BITS'(1))) begin
               res.status = STATUS_RANGE;
            end else begin
               res.read_data = ring_mem[item.index[ADDR_BITS-1:0]];
            end
         end
      endcase
      res.fill_count  = FILL_COUNT_BITS'(held_bytes());
      res.first_index = ring_head;
      res.next_index  = ring_tail;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // result checker
   // ---------------------------------------------------------------------

   always @(negedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (ring_results_q.size() == 0) begin
            $error("result transfer with no command outstanding");
            mismatch_count++;
         end else begin
            want = ring_results_q.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               mismatch_count++;
            end
            if (rsp_data.read_data !== want.read_data) begin
               $error("read_data: expected %0h, actual %0h",
                      want.read_data, rsp_data.read_data);
               mismatch_count++;
            end
            if (rsp_data.fill_count !== want.fill_count) begin
               $error("fill_count: expected %0d, actual %0d",
                      want.fill_count, rsp_data.fill_count);
               mismatch_count++;
            end
            if (rsp_data.first_index !== want.first_index) begin
               $error("first_index: expected %0h, actual %0h",
                      want.first_index, rsp_data.first_index);
               mismatch_count++;
            end
            if (rsp_data.next_index !== want.next_index) begin
               $error("next_index: expected %0h, actual %0h",
                      want.next_index, rsp_data.next_index);
               mismatch_count++;
            end
            if (rsp_data.run_end !== want.run_end) begin
               $error("run_end: expected %0d, actual %0d", want.run_end, rsp_data.run_end);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // command driver
   // ---------------------------------------------------------------------

   // one command transfer; in each cycle the sender holds start low with
   // a chance of idle_pct in a hundred
   task automatic send_item(req_type item);
      bit taken;
      req_data <= item;
      do begin
         start <= ($urandom_range(99) >= idle_pct);
         @(negedge clock);
         taken = start && !busy;
         @(posedge clock);
      end while (!taken);
      ring_results_q.push_back(ring_apply(item));
   endtask

   // hold off commands until every result is back
   task automatic wait_drained();
      start <= 1'b0;
      while (ring_results_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_overwrite_mode(bit value);
      bit taken;
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid <= 1'b0;
      wrap_mode = value;
   endtask

   function automatic req_type make_item(kind_type kind, logic [BYTE_BITS-1:0] data,
                                         logic [PORT_INDEX_BITS-1:0] idx, logic last);
      req_type item;
      item.kind       = kind;
      item.write_data = data;
      item.index      = idx;
      item.last       = last;
      return item;
   endfunction

   // index for write or read: half inside the ring, some at or just past its edges,
   // some anywhere in the index space
   function automatic logic [INDEX_BITS-1:0] pick_index();
      int sel;
      sel = $urandom_range(99);
      if (sel < 50) begin
         return ring_head + $urandom_range(held_bytes());
      end else if (sel < 65) begin
         return ring_tail;
      end else if (sel < 75) begin
         return ring_tail + 1 + $urandom_range(2);
      end else if (sel < 85) begin
         return ring_head - 1 - $urandom_range(2);
      end
      return $urandom;
   endfunction

   // random command; a growing pass switches to a mixed profile near full
   function automatic req_type random_item(int push_w, int pop_w, int write_w, bit grow);
      req_type item;
      int      pick;
      int      pw;
      int      ow;
      int      ww;
      pw = push_w;
      ow = pop_w;
      ww = write_w;
      if (grow && held_bytes() + 8 >= CAPACITY_INDEX) begin
         pw = 35;
         ow = 15;
         ww = 25;
      end
      item.write_data = BYTE_BITS'($urandom);
      item.index      = $urandom;
      item.last       = 1'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < pw) begin
         item.kind = KIND_PUSH;
      end else if (pick < pw + ow) begin
         item.kind = KIND_POP;
      end else if (pick < pw + ow + ww) begin
         item.kind  = KIND_WRITE;
         item.index = pick_index();
      end else begin
         item.kind  = KIND_READ;
         item.index = pick_index();
      end
      return item;
   endfunction

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // empty ring, range checks at both edges, write extending the end
   task automatic test_empty_ring();
      send_item(make_item(KIND_POP, 8'h00, 32'h0000_0000, 1'b0));
      send_item(make_item(KIND_READ, 8'h00, ring_head, 1'b0));
      send_item(make_item(KIND_READ, 8'hFF, 32'h0000_0000, 1'b1));
      send_item(make_item(KIND_READ, 8'h00, 32'hFFFF_FFFF, 1'b1));
      send_item(make_item(KIND_WRITE, 8'h11, ring_head - INDEX_BITS'(1), 1'b0));
      send_item(make_item(KIND_WRITE, 8'h22, ring_tail + INDEX_BITS'(1), 1'b0));
      send_item(make_item(KIND_PUSH, 8'h00, 32'hFFFF_FFFF, 1'b0));
      send_item(make_item(KIND_PUSH, 8'hFF, 32'h0000_0000, 1'b1));
      send_item(make_item(KIND_READ, 8'h00, ring_head, 1'b0));
      send_item(make_item(KIND_READ, 8'h00, ring_head + INDEX_BITS'(1), 1'b0));
      send_item(make_item(KIND_READ, 8'h00, ring_tail, 1'b1));
      send_item(make_item(KIND_WRITE, 8'hA5, ring_tail, 1'b0));
      send_item(make_item(KIND_WRITE, 8'h5A, ring_head, 1'b1));
      repeat (4) send_item(make_item(KIND_POP, 8'hFF, 32'hFFFF_FFFF, 1'b1));
   endtask

   // overwrite mode on and back off
   task automatic test_mode_toggle();
      write_overwrite_mode(1'b1);
      send_item(make_item(KIND_PUSH, 8'h3C, 32'hFFFF_FFFF, 1'b0));
      write_overwrite_mode(1'b0);
      send_item(make_item(KIND_POP, 8'hC3, 32'h0000_0000, 1'b1));
   endtask

   task automatic run_random(int count, int push_w, int pop_w, int write_w, bit grow,
                             bit pause_midway);
      for (int i = 0; i < count; i++) begin
         if (pause_midway && i == count / 2) begin
            wait_drained();
         end
         send_item(random_item(push_w, pop_w, write_w, grow));
      end
   endtask

   // fill the ring, then hover at full with refused pushes
   task automatic test_fill_no_overwrite();
      write_overwrite_mode(1'b0);
      idle_pct = 18;
      run_random(1150, 93, 1, 3, 1'b1, 1'b0);
   endtask

   // full ring with overwrite on
   task automatic test_full_overwrite();
      write_overwrite_mode(1'b1);
      idle_pct = 87;
      run_random(300, 35, 15, 25, 1'b0, 1'b0);
   endtask

   // drain back down at full rate, with one pause midway
   task automatic test_drain();
      write_overwrite_mode(1'b0);
      idle_pct = 0;
      run_random(400, 5, 75, 10, 1'b0, 1'b1);
   endtask

   initial begin
      ring_head = RESET_INDEX;
      ring_tail = RESET_INDEX;
      wrap_mode = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_empty_ring();
      test_mode_toggle();
      test_fill_no_overwrite();
      test_full_overwrite();
      test_drain();
      wait_drained();
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
